// ----- src/ffha_pkg.sv -----
// Shared types, operation codes and layout constants for the first-fit heap allocator.
// Used by the controller, the datapath, the top level and the port checker.
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;

  localparam int HEAP_BYTES_DEF        = 1500;
  localparam int SMALL_BLOCK_COUNT_DEF = 8;
  localparam int SMALL_BLOCK_BYTES_DEF = 16;

  localparam int POS_W        = 16;
  localparam int LEN_W        = 15;
  localparam int HDR_BYTES    = 2;
  localparam int MIN_SPLIT    = 4;
  localparam int LL_PAYLOAD   = 417;
  localparam int LL_HEADERS   = 19;
  localparam int LL_BLOCK_BYTES = ((LL_PAYLOAD + 1) / 2) * 2 + LL_HEADERS * HDR_BYTES;
  localparam int KICK_REQUEST = 1;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_KICK  = 2'd1;
  localparam logic [1:0] OP_ALLOC = 2'd2;
  localparam logic [1:0] OP_FREE  = 2'd3;

  localparam logic RD_HDR  = 1'b0;
  localparam logic RD_FREE = 1'b1;

  localparam logic [3:0] WR_NONE       = 4'd0;
  localparam logic [3:0] WR_INIT_SENT  = 4'd1;
  localparam logic [3:0] WR_INIT_SMALL = 4'd2;
  localparam logic [3:0] WR_INIT_GUARD = 4'd3;
  localparam logic [3:0] WR_INIT_BIG   = 4'd4;
  localparam logic [3:0] WR_MERGE      = 4'd5;
  localparam logic [3:0] WR_REM        = 4'd6;
  localparam logic [3:0] WR_HDR_FULL   = 4'd7;
  localparam logic [3:0] WR_HDR_SIZE   = 4'd8;
  localparam logic [3:0] WR_FREE       = 4'd9;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] request_size;
    logic [10:0] block_address;
  } ffha_item_t;

  typedef struct packed {
    logic        ok;
    logic [10:0] payload_address;
  } ffha_result_t;

  typedef struct packed {
    logic       load;
    logic       setup;
    logic       rd_en;
    logic       rd_src;
    logic [3:0] wr_sel;
    logic       step_inuse;
    logic       step_run;
    logic       take_direct;
    logic       merge;
    logic       advance;
    logic       init_ff;
    logic       finish;
    logic       fin_ok;
    logic       fin_pay;
    logic       kick_ok;
    logic       kick_fail;
  } ffha_cmd_t;

  typedef struct packed {
    logic zero;
    logic in_use;
    logic coal;
    logic fits;
    logic merge_fits;
    logic len_zero;
    logic rem_ok;
    logic is_kick;
  } ffha_stat_t;

endpackage
`default_nettype wire

// ----- src/ffha_ctrl.sv -----
// Controller state machine of the heap allocator: sequences init, walk, merge,
// split and free steps. Depends on ffha_pkg for command and status types.
`timescale 1ns / 1ps
`default_nettype none
module ffha_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  wire [1:0]              kind,
  input  ffha_pkg::ffha_stat_t   stat,
  output ffha_pkg::ffha_cmd_t    cmd,
  output logic                   busy
);
  import ffha_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_INIT0     = 4'd1;
  localparam logic [3:0] S_INIT1     = 4'd2;
  localparam logic [3:0] S_INIT2     = 4'd3;
  localparam logic [3:0] S_INIT3     = 4'd4;
  localparam logic [3:0] S_SETUP     = 4'd5;
  localparam logic [3:0] S_RD        = 4'd6;
  localparam logic [3:0] S_EVAL      = 4'd7;
  localparam logic [3:0] S_RERD      = 4'd8;
  localparam logic [3:0] S_LEN       = 4'd9;
  localparam logic [3:0] S_SPLIT     = 4'd10;
  localparam logic [3:0] S_SPLIT_HDR = 4'd11;
  localparam logic [3:0] S_FREE_RD   = 4'd12;
  localparam logic [3:0] S_FREE_WR   = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       boot;
  logic       boot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT0;
      boot  <= 1'b1;
    end else begin
      state <= state_next;
      boot  <= boot_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    boot_next  = boot;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (kind)
            OP_INIT:  state_next = S_INIT0;
            OP_FREE:  state_next = S_FREE_RD;
            default:  state_next = S_SETUP;
          endcase
        end
      end
      S_INIT0: begin
        cmd.wr_sel  = WR_INIT_SENT;
        cmd.init_ff = 1'b1;
        state_next  = S_INIT1;
      end
      S_INIT1: begin
        cmd.wr_sel = WR_INIT_SMALL;
        state_next = S_INIT2;
      end
      S_INIT2: begin
        cmd.wr_sel = WR_INIT_GUARD;
        state_next = S_INIT3;
      end
      S_INIT3: begin
        cmd.wr_sel = WR_INIT_BIG;
        cmd.finish = !boot;
        cmd.fin_ok = 1'b1;
        boot_next  = 1'b0;
        state_next = S_IDLE;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_HDR;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (stat.zero || (stat.in_use && stat.len_zero)) begin
          cmd.finish    = 1'b1;
          cmd.kick_fail = stat.is_kick;
          state_next    = S_IDLE;
        end else if (stat.in_use) begin
          cmd.step_inuse = 1'b1;
          state_next     = S_RD;
        end else if (!stat.coal) begin
          if (stat.fits) begin
            cmd.take_direct = 1'b1;
            state_next      = S_SPLIT;
          end else begin
            cmd.step_run = 1'b1;
            state_next   = S_RD;
          end
        end else begin
          cmd.merge  = 1'b1;
          cmd.wr_sel = WR_MERGE;
          state_next = stat.merge_fits ? S_SPLIT : S_RERD;
        end
      end
      S_RERD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_HDR;
        state_next = S_LEN;
      end
      S_LEN: begin
        if (stat.len_zero) begin
          cmd.finish    = 1'b1;
          cmd.kick_fail = stat.is_kick;
          state_next    = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_RD;
        end
      end
      S_SPLIT: begin
        if (stat.rem_ok) begin
          cmd.wr_sel = WR_REM;
          state_next = S_SPLIT_HDR;
        end else begin
          cmd.wr_sel  = WR_HDR_FULL;
          cmd.finish  = 1'b1;
          cmd.fin_ok  = 1'b1;
          cmd.fin_pay = !stat.is_kick;
          cmd.kick_ok = stat.is_kick;
          state_next  = S_IDLE;
        end
      end
      S_SPLIT_HDR: begin
        cmd.wr_sel  = WR_HDR_SIZE;
        cmd.finish  = 1'b1;
        cmd.fin_ok  = 1'b1;
        cmd.fin_pay = !stat.is_kick;
        cmd.kick_ok = stat.is_kick;
        state_next  = S_IDLE;
      end
      S_FREE_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_FREE;
        state_next = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd.wr_sel = WR_FREE;
        cmd.finish = 1'b1;
        cmd.fin_ok = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/ffha_datapath.sv -----
// Datapath of the heap allocator: header store in two byte banks, walk registers,
// first-free pointer and result register. Depends on ffha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffha_datapath #(
  parameter int HEAP_BYTES        = ffha_pkg::HEAP_BYTES_DEF,
  parameter int SMALL_BLOCK_COUNT = ffha_pkg::SMALL_BLOCK_COUNT_DEF,
  parameter int SMALL_BLOCK_BYTES = ffha_pkg::SMALL_BLOCK_BYTES_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  ffha_pkg::ffha_item_t    item,
  input  ffha_pkg::ffha_cmd_t     cmd,
  output ffha_pkg::ffha_stat_t    stat,
  output logic                    done,
  output ffha_pkg::ffha_result_t  result
);
  import ffha_pkg::*;

  localparam int ROWS       = (HEAP_BYTES + 1) / 2;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int SMALL_BLK  = ((SMALL_BLOCK_BYTES + 1) / 2) * 2;
  localparam int SMALL_ZONE = SMALL_BLK * SMALL_BLOCK_COUNT + LL_BLOCK_BYTES;
  localparam int BIG_RAW    = HEAP_BYTES - SMALL_ZONE - 2 * HDR_BYTES;
  localparam int BIG_LEN    = (BIG_RAW < 0) ? 0 : BIG_RAW;

  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(HEAP_BYTES - 2);
  localparam logic [POS_W-1:0] SENT_POS   = POS_W'((HEAP_BYTES / HDR_BYTES - 1) * HDR_BYTES);
  localparam logic [POS_W-1:0] GUARD_POS  = POS_W'(SMALL_ZONE);
  localparam logic [POS_W-1:0] BIG_POS    = POS_W'(SMALL_ZONE + HDR_BYTES);
  localparam logic [POS_W-1:0] SMALL_LIM  = POS_W'(SMALL_BLK);
  localparam logic [POS_W-1:0] HDR_INC    = POS_W'(HDR_BYTES);
  localparam logic [15:0]      SMALL_HDR  = {1'b0, LEN_W'(SMALL_ZONE)};
  localparam logic [15:0]      GUARD_HDR  = {1'b1, LEN_W'(HDR_BYTES)};
  localparam logic [15:0]      BIG_HDR    = {1'b0, LEN_W'(BIG_LEN)};
  localparam logic [15:0]      SPLIT_MIN  = 16'(MIN_SPLIT);

  logic [7:0] even_mem [ROWS];
  logic [7:0] odd_mem  [ROWS];
  logic [7:0] even_q;
  logic [7:0] odd_q;
  logic       rd_odd_q;
  logic       rd_ok_q;

  logic [1:0]       op_kind;
  logic [10:0]      req;
  logic [10:0]      addr;
  logic [POS_W-1:0] hdr;
  logic [POS_W-1:0] prev;
  logic [15:0]      prev_val;
  logic [15:0]      cur_val;
  logic [15:0]      size;
  logic             coal;
  logic [POS_W-1:0] first_free;
  logic             kicked;

  logic [15:0]      rdata;
  logic [POS_W-1:0] free_pos;
  logic [POS_W-1:0] rd_pos;
  logic [POS_W-2:0] rd_half;
  logic [POS_W-2:0] rd_half_up;
  logic             rd_ok;
  logic [POS_W-1:0] wr_pos;
  logic [15:0]      wr_data;
  logic [POS_W-2:0] wr_half;
  logic [POS_W-2:0] wr_half_up;
  logic             wr_ok;
  logic [LEN_W-1:0] plen;
  logic [15:0]      rem;
  logic [15:0]      size_calc;
  logic [POS_W-1:0] step_pos;
  logic             is_kick;
  logic [POS_W-1:0] pay_pos;

  assign is_kick  = (op_kind == OP_KICK);
  assign rdata    = rd_ok_q ? (rd_odd_q ? {even_q, odd_q} : {odd_q, even_q}) : 16'd0;
  assign free_pos = {{(POS_W - 11){1'b0}}, addr} - HDR_INC;
  assign plen     = prev_val[LEN_W-1:0] + rdata[LEN_W-1:0];
  assign rem      = {1'b0, cur_val[LEN_W-1:0]} - size;
  assign step_pos = hdr + {1'b0, rdata[LEN_W-1:0]};
  assign pay_pos  = hdr + HDR_INC;
  assign size_calc = is_kick ? 16'(KICK_REQUEST + HDR_BYTES) : ({5'd0, req} + 16'(HDR_BYTES));

  assign stat.zero       = (rdata == 16'd0);
  assign stat.in_use     = rdata[15];
  assign stat.coal       = coal;
  assign stat.fits       = ({1'b0, rdata[LEN_W-1:0]} >= size);
  assign stat.merge_fits = ({1'b0, plen} >= size);
  assign stat.len_zero   = (rdata[LEN_W-1:0] == '0);
  assign stat.rem_ok     = (rem >= SPLIT_MIN);
  assign stat.is_kick    = is_kick;

  // A header spans byte pos and pos+1, which always fall in different banks.
  assign rd_pos     = (cmd.rd_src == RD_FREE) ? free_pos : hdr;
  assign rd_half    = rd_pos[POS_W-1:1];
  assign rd_half_up = rd_half + (POS_W - 1)'(rd_pos[0]);
  assign rd_ok      = cmd.rd_en && (rd_pos <= LAST_POS);

  always_comb begin
    case (cmd.wr_sel)
      WR_INIT_SENT: begin
        wr_pos  = SENT_POS;
        wr_data = 16'd0;
      end
      WR_INIT_SMALL: begin
        wr_pos  = '0;
        wr_data = SMALL_HDR;
      end
      WR_INIT_GUARD: begin
        wr_pos  = GUARD_POS;
        wr_data = GUARD_HDR;
      end
      WR_INIT_BIG: begin
        wr_pos  = BIG_POS;
        wr_data = BIG_HDR;
      end
      WR_MERGE: begin
        wr_pos  = prev;
        wr_data = {prev_val[15], plen};
      end
      WR_REM: begin
        wr_pos  = hdr + size;
        wr_data = rem;
      end
      WR_HDR_FULL: begin
        wr_pos  = hdr;
        wr_data = {!is_kick, cur_val[LEN_W-1:0]};
      end
      WR_HDR_SIZE: begin
        wr_pos  = hdr;
        wr_data = {!is_kick, size[LEN_W-1:0]};
      end
      WR_FREE: begin
        wr_pos  = free_pos;
        wr_data = {1'b0, rdata[LEN_W-1:0]};
      end
      default: begin
        wr_pos  = '0;
        wr_data = 16'd0;
      end
    endcase
  end

  assign wr_ok      = (cmd.wr_sel != WR_NONE) && (wr_pos <= LAST_POS);
  assign wr_half    = wr_pos[POS_W-1:1];
  assign wr_half_up = wr_half + (POS_W - 1)'(wr_pos[0]);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      even_mem[wr_half_up[ROW_W-1:0]] <= wr_pos[0] ? wr_data[15:8] : wr_data[7:0];
    end
    if (rd_ok) begin
      even_q <= even_mem[rd_half_up[ROW_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      odd_mem[wr_half[ROW_W-1:0]] <= wr_pos[0] ? wr_data[7:0] : wr_data[15:8];
    end
    if (rd_ok) begin
      odd_q <= odd_mem[rd_half[ROW_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_odd_q <= rd_pos[0];
      rd_ok_q  <= rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind <= item.kind;
      req     <= item.request_size;
      addr    <= item.block_address;
    end
    if (cmd.setup) begin
      size <= size_calc;
      hdr  <= (!kicked || (size_calc <= SMALL_LIM)) ? first_free : BIG_POS;
      coal <= 1'b0;
    end
    if (cmd.step_inuse) begin
      coal <= 1'b0;
      hdr  <= step_pos;
    end
    if (cmd.step_run) begin
      coal     <= 1'b1;
      prev     <= hdr;
      prev_val <= rdata;
      hdr      <= step_pos;
    end
    if (cmd.take_direct) begin
      cur_val <= rdata;
    end
    if (cmd.merge) begin
      prev_val <= {prev_val[15], plen};
      if (stat.merge_fits) begin
        hdr     <= prev;
        cur_val <= {prev_val[15], plen};
      end
    end
    if (cmd.advance) begin
      hdr <= step_pos;
    end
    if (cmd.finish) begin
      result.ok              <= cmd.fin_ok;
      result.payload_address <= cmd.fin_pay ? pay_pos[10:0] : 11'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_free <= '0;
      kicked     <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.init_ff) begin
        first_free <= '0;
      end
      if (cmd.kick_ok) begin
        first_free <= hdr;
        kicked     <= 1'b1;
      end
      if (cmd.kick_fail) begin
        kicked <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/first_fit_heap_allocator_core.sv -----
// Allocate and kick walk the headers: they step over blocks in use, merge short free runs,
// and fail at the end or take a block whole or split one; init and free take no walk.
// One item at a time: the next beat is taken in the result cycle. Each result shows for
// one cycle under done; receivers cannot stall.
// Reset: synchronous; after rst the block writes the 4 layout headers while busy is high.
// Top level of the first-fit heap allocator; uses ffha_pkg, ffha_ctrl, ffha_datapath.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_heap_allocator_core #(
  parameter int HEAP_BYTES        = ffha_pkg::HEAP_BYTES_DEF,
  parameter int SMALL_BLOCK_COUNT = ffha_pkg::SMALL_BLOCK_COUNT_DEF,
  parameter int SMALL_BLOCK_BYTES = ffha_pkg::SMALL_BLOCK_BYTES_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  output logic                    busy,
  input  ffha_pkg::ffha_item_t    item,
  output logic                    done,
  output ffha_pkg::ffha_result_t  result
);
  import ffha_pkg::*;

  ffha_cmd_t  cmd;
  ffha_stat_t stat;

  ffha_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (item.kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ffha_datapath #(
    .HEAP_BYTES        (HEAP_BYTES),
    .SMALL_BLOCK_COUNT (SMALL_BLOCK_COUNT),
    .SMALL_BLOCK_BYTES (SMALL_BLOCK_BYTES)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule
`default_nettype wire

// ----- src/ffha_checker.sv -----
// Port-level checker for the heap allocator top level, attached by bind.
// Depends on ffha_pkg for the result beat type.
`timescale 1ns / 1ps
`default_nettype none
module ffha_checker (
  input wire                     clk,
  input wire                     rst,
  input wire                     start,
  input wire                     busy,
  input wire                     done,
  input ffha_pkg::ffha_result_t  result
);
  import ffha_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted beat");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without preceding work");

  a_boot_busy: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> busy)
    else $error("layout write after reset not shown as busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.ok) |-> (result.payload_address == 11'd0))
    else $error("failed result beat carries an address");

  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("more than one result beat for one item");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for first_fit_heap_allocator_core: a directed table, then random
// mixed, fill and drain phases, checked against a byte-level model of the header heap kept here.
// Depends on ffha_pkg and the allocator RTL only.
`timescale 1ns / 1ps
module tb;
  import ffha_pkg::*;

  localparam int HEAP         = HEAP_BYTES_DEF;
  localparam int SMALL_BLK    = ((SMALL_BLOCK_BYTES_DEF + 1) / 2) * 2;
  localparam int SMALL_ZONE   = SMALL_BLK * SMALL_BLOCK_COUNT_DEF + LL_BLOCK_BYTES;
  localparam int GUARD_POS    = SMALL_ZONE;
  localparam int BIG_POS      = SMALL_ZONE + HDR_BYTES;
  localparam int SENTINEL_POS = (HEAP / HDR_BYTES - 1) * HDR_BYTES;
  localparam int BIG_LEN      = HEAP - SMALL_ZONE - 2 * HDR_BYTES;
  localparam int unsigned IN_USE   = 32'h8000;
  localparam int unsigned LEN_MASK = 32'h7fff;
  localparam int DIR_ROWS     = 24;
  localparam int RAND_OPS     = 1026;
  localparam int QUIET_LIMIT  = 40000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] req;
    logic [10:0] addr;
    logic        typed;
    logic        ok;
    logic [10:0] pay;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         start;
  logic         busy;
  ffha_item_t   item;
  logic         done;
  ffha_result_t result;

  logic [7:0]   heap_img [HEAP];
  bit           hdr_known [HEAP];
  int unsigned  free_head;
  bit           kick_seen;
  bit           read_unknown;

  logic [7:0]   heap_save [HEAP];
  bit           known_save [HEAP];
  int unsigned  head_save;
  bit           kick_save;

  ffha_result_t pending_results [$];
  int           live_blocks [$];
  int           mismatch_count = 0;
  int           quiet_cycles = 0;
  int           sender_idle_pct = 20;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_INIT,  11'd0,    11'd0,    1'b1, 1'b1, 11'd0},
    '{OP_ALLOC, 11'd0,    11'd0,    1'b1, 1'b1, 11'd2},
    '{OP_ALLOC, 11'd2047, 11'd0,    1'b1, 1'b0, 11'd0},
    '{OP_FREE,  11'd0,    11'd0,    1'b1, 1'b1, 11'd0},
    '{OP_FREE,  11'd0,    11'd1,    1'b1, 1'b1, 11'd0},
    '{OP_FREE,  11'd2047, 11'd2047, 1'b1, 1'b1, 11'd0},
    '{OP_FREE,  11'd0,    11'd2,    1'b1, 1'b1, 11'd0},
    '{OP_ALLOC, 11'd1,    11'd0,    1'b0, 1'b0, 11'd0},
    '{OP_ALLOC, 11'd581,  11'd0,    1'b0, 1'b0, 11'd0},
    '{OP_KICK,  11'd0,    11'd0,    1'b0, 1'b0, 11'd0},
    '{OP_ALLOC, 11'd16,   11'd0,    1'b0, 1'b0, 11'd0},
    '{OP_ALLOC, 11'd14,   11'd0,    1'b0, 1'b0, 11'd0},
    '{OP_ALLOC, 11'd910,  11'd0,    1'b0, 1'b0, 11'd0},
    '{OP_FREE,  11'd0,    11'd1500, 1'b1, 1'b1, 11'd0},
    '{OP_FREE,  11'd0,    11'd1501, 1'b1, 1'b1, 11'd0},
    '{OP_INIT,  11'd2047, 11'd2047, 1'b1, 1'b1, 11'd0},
    '{OP_ALLOC, 11'd582,  11'd0,    1'b1, 1'b1, 11'd588},
    '{OP_ALLOC, 11'd14,   11'd0,    1'b0, 1'b0, 11'd0},
    '{OP_ALLOC, 11'd908,  11'd0,    1'b0, 1'b0, 11'd0},
    '{OP_KICK,  11'd0,    11'd0,    1'b0, 1'b0, 11'd0},
    '{OP_ALLOC, 11'd2047, 11'd0,    1'b1, 1'b0, 11'd0},
    '{OP_FREE,  11'd0,    11'd588,  1'b1, 1'b1, 11'd0},
    '{OP_ALLOC, 11'd0,    11'd0,    1'b0, 1'b0, 11'd0},
    '{OP_ALLOC, 11'd910,  11'd0,    1'b0, 1'b0, 11'd0}
  };

  first_fit_heap_allocator_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned hdr_read(int unsigned pos);
    if (pos + 1 >= HEAP) return 0;
    if (!hdr_known[pos] || !hdr_known[pos + 1]) read_unknown = 1'b1;
    return 32'({heap_img[pos + 1], heap_img[pos]});
  endfunction

  function automatic void hdr_write(int unsigned pos, int unsigned v);
    if (pos + 1 >= HEAP) return;
    heap_img[pos]      = v[7:0];
    heap_img[pos + 1]  = v[15:8];
    hdr_known[pos]     = 1'b1;
    hdr_known[pos + 1] = 1'b1;
  endfunction

  function automatic void heap_layout_init();
    hdr_write(SENTINEL_POS, 0);
    free_head = 0;
    hdr_write(0, SMALL_ZONE & LEN_MASK);
    hdr_write(GUARD_POS, HDR_BYTES | IN_USE);
    hdr_write(BIG_POS, (BIG_LEN < 0 ? 0 : BIG_LEN) & LEN_MASK);
  endfunction

  // First-fit walk with merging of free runs; returns the payload offset or 0.
  function automatic int unsigned predict_alloc(int unsigned req);
    int unsigned size, pos, prev, v, pv, plen, len, rem;
    bit merging, found;
    size = (req + HDR_BYTES) & 32'hffff;
    pos = (!kick_seen || size <= SMALL_BLK) ? free_head : BIG_POS;
    prev = 0;
    merging = 1'b0;
    found = 1'b0;
    while (1) begin
      v = hdr_read(pos);
      if ((v & IN_USE) != 0) begin
        merging = 1'b0;
      end else if (merging) begin
        pv = hdr_read(prev);
        plen = ((pv & LEN_MASK) + (v & LEN_MASK)) & LEN_MASK;
        hdr_write(prev, (pv & IN_USE) | plen);
        if (plen >= size) begin
          pos = prev;
          found = 1'b1;
          break;
        end
      end else begin
        if ((v & LEN_MASK) >= size) begin
          found = 1'b1;
          break;
        end
        merging = 1'b1;
        prev = pos;
      end
      len = hdr_read(pos) & LEN_MASK;
      if (len == 0) break;
      pos += len;
      if (hdr_read(pos) == 0) break;
    end
    if (!found) return 0;
    v = hdr_read(pos);
    rem = ((v & LEN_MASK) - size) & 32'hffff;
    if (rem >= MIN_SPLIT) begin
      hdr_write(pos + size, rem);
      hdr_write(pos, (size | IN_USE) & 32'hffff);
    end else begin
      hdr_write(pos, v | IN_USE);
    end
    return pos + HDR_BYTES;
  endfunction

  function automatic void heap_release(int unsigned addr);
    int unsigned pos;
    if (addr < HDR_BYTES) return;
    pos = addr - HDR_BYTES;
    if (pos + 1 >= HEAP) return;
    hdr_write(pos, hdr_read(pos) & ~IN_USE & 32'hffff);
  endfunction

  function automatic ffha_result_t heap_op_result(ffha_item_t it);
    ffha_result_t r;
    int unsigned p;
    r.ok = 1'b1;
    r.payload_address = '0;
    case (it.kind)
      OP_INIT: begin
        heap_layout_init();
      end
      OP_KICK: begin
        p = predict_alloc(KICK_REQUEST);
        if (p != 0) begin
          free_head = p - HDR_BYTES;
          heap_release(p);
        end else begin
          r.ok = 1'b0;
        end
        kick_seen = 1'b1;
      end
      OP_ALLOC: begin
        p = predict_alloc(it.request_size);
        if (p != 0) r.payload_address = p[10:0];
        else r.ok = 1'b0;
      end
      default: begin
        heap_release(it.block_address);
      end
    endcase
    return r;
  endfunction

  // One beat per operation; the expected result is queued once the block is no longer busy.
  task automatic send_op(input ffha_item_t it, input bit typed, input ffha_result_t typed_res);
    ffha_item_t   sent;
    ffha_result_t r;
    bit           use_typed;
    sent         = it;
    use_typed    = typed;
    heap_save    = heap_img;
    known_save   = hdr_known;
    head_save    = free_head;
    kick_save    = kick_seen;
    read_unknown = 1'b0;
    r = heap_op_result(sent);
    // An operation that would read never-written header bytes is sent as an init instead.
    if (read_unknown) begin
      heap_img  = heap_save;
      hdr_known = known_save;
      free_head = head_save;
      kick_seen = kick_save;
      sent.kind = OP_INIT;
      use_typed = 1'b0;
      r = heap_op_result(sent);
    end
    if (use_typed) r = typed_res;
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start <= 1'b1;
    item  <= sent;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(r);
    if (sent.kind == OP_ALLOC && r.ok) live_blocks.push_back(int'(r.payload_address));
    if (sent.kind == OP_INIT) live_blocks.delete();
  endtask

  always @(posedge clk) begin
    ffha_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("tb: result with nothing pending: ok=%0d pay=%0d",
                   result.ok, result.payload_address);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.ok !== want.ok || result.payload_address !== want.payload_address) begin
          if (mismatch_count < 10)
            $display("tb: mismatch at %0t: ok exp %0d got %0d, pay exp %0d got %0d",
                     $realtime, want.ok, result.ok, want.payload_address,
                     result.payload_address);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: timeout, no beat in %0d cycles", QUIET_LIMIT);
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    ffha_item_t   it;
    ffha_result_t typed_res;
    int phase, roll, cand, idx, tries;
    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;
    for (int i = 0; i < HEAP; i++) begin
      heap_img[i]  = 8'h00;
      hdr_known[i] = 1'b0;
    end
    kick_seen = 1'b0;
    heap_layout_init();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      it.kind          = dir_rows[i].kind;
      it.request_size  = dir_rows[i].req;
      it.block_address = dir_rows[i].addr;
      typed_res.ok              = dir_rows[i].ok;
      typed_res.payload_address = dir_rows[i].pay;
      send_op(it, dir_rows[i].typed, typed_res);
    end

    typed_res = '0;
    for (int n = 0; n < RAND_OPS; n++) begin
      if (n % 500 == 0) begin
        start <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      sender_idle_pct = (n >= 300 && n < 600) ? 0 : 20;
      // Phases of 150 operations: mixed traffic, filling the heap, draining it.
      phase = (n / 150) % 3;
      roll = $urandom_range(99);
      it.request_size  = 11'($urandom_range(2047));
      it.block_address = 11'($urandom_range(2047));
      if ((phase == 1 && roll < 72) || (phase == 2 && roll < 25) ||
          (phase == 0 && roll < 45)) begin
        it.kind = OP_ALLOC;
        roll = $urandom_range(99);
        if (roll < 55) it.request_size = 11'($urandom_range(0, 8));
        else if (roll < 88) it.request_size = 11'($urandom_range(9, 64));
        else if (roll < 97) it.request_size = 11'($urandom_range(65, 450));
        else it.request_size = 11'($urandom_range(451, 2047));
      end else if ((phase == 1 && roll < 85) || (phase != 1 && roll < 85 - 5 * (phase == 0))) begin
        it.kind = OP_FREE;
        roll = $urandom_range(99);
        if (live_blocks.size() > 0 && roll < 70) begin
          idx = $urandom_range(live_blocks.size() - 1);
          it.block_address = 11'(live_blocks[idx]);
          live_blocks.delete(idx);
        end else if (roll < 88) begin
          // Any spot whose two header bytes have been written at some point, else address 0.
          it.block_address = '0;
          for (tries = 0; tries < 16; tries++) begin
            cand = $urandom_range(2, HEAP);
            if (hdr_known[cand - 2] && hdr_known[cand - 1]) begin
              it.block_address = 11'(cand);
              break;
            end
          end
        end else begin
          it.block_address = $urandom_range(1) ? 11'($urandom_range(0, 1))
                                               : 11'($urandom_range(HEAP + 1, 2047));
        end
      end else if ((phase == 1 && roll < 99) || (phase == 2 && roll < 95) ||
                   (phase == 0 && roll < 94)) begin
        it.kind = OP_KICK;
      end else begin
        it.kind = OP_INIT;
      end
      send_op(it, 1'b0, typed_res);
    end

    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
src/ffha_pkg.sv
src/ffha_ctrl.sv
src/ffha_datapath.sv
src/first_fit_heap_allocator_core.sv
src/ffha_checker.sv
verif/tb.sv
